FILE: sv/swm_pkg.sv
// swm_pkg: shared types and fixed widths for the sliding window maximum block
// no dependencies; used by sliding_window_maximum_top and swm_checker

package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 7;
    localparam int TDATA_W  = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DROP_RD,
        S_DROP_CMP,
        S_EVICT_RD,
        S_EVICT_CMP,
        S_PUSH
    } t_swm_state;

endpackage

FILE: sv/sliding_window_maximum_top.sv
// Sliding window maximum over signed 32-bit samples: emits the largest of the
// last window_size samples once that many samples of a sequence have arrived.
// The candidate queue lives in one circular memory that a small sequencer
// visits one entry at a time through a single registered read port and one
// compare unit. For each item the sequencer reads and drops the head entries
// that have aged out of the window, then reads and evicts the tail entries
// no larger than the new sample, then pushes the sample; the push step waits
// while the output register holds an undrained result. The slave side is not
// ready while an item is in work; a finished result waits in an
// output register. tuser carries the first flag, tlast the last flag.
// depends on swm_pkg

module sliding_window_maximum_top #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration: window_size
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [swm_pkg::CFG_W-1:0]   i_cfg_data,
    // input beat
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [swm_pkg::TDATA_W-1:0] i_s_tdata,   // [31:0] sample
    input  logic                        i_s_tuser,   // [0] first
    input  logic                        i_s_tlast,
    // output beat
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [swm_pkg::TDATA_W-1:0] o_m_tdata,   // [31:0] window_max
    output logic                        o_m_tlast
);

    localparam int IW      = $clog2(WINDOW_MAX);
    localparam int LW      = $clog2(WINDOW_MAX + 1);
    localparam int PW      = $clog2(2 * WINDOW_MAX);
    localparam int CW      = (LW > swm_pkg::CFG_W) ? LW : swm_pkg::CFG_W;
    localparam int AW      = (PW > CW) ? PW : CW;
    localparam int SW      = LW + 1;
    localparam int POS_MOD = 2 * WINDOW_MAX;
    localparam int EW      = swm_pkg::SAMPLE_W + PW;

    swm_pkg::t_swm_state r_state, n_state;

    logic [swm_pkg::CFG_W-1:0]    r_window_size, n_window_size;
    logic signed [swm_pkg::SAMPLE_W-1:0] r_sample, n_sample;
    logic                         r_last, n_last;
    logic [LW-1:0]                r_qlen, n_qlen;
    logic [IW-1:0]                r_head, n_head;
    logic [PW-1:0]                r_pos, n_pos;
    logic [LW-1:0]                r_seen, n_seen;
    logic signed [swm_pkg::SAMPLE_W-1:0] r_head_val, n_head_val;
    logic                         r_out_valid, n_out_valid;
    logic [swm_pkg::SAMPLE_W-1:0] r_out_data, n_out_data;
    logic                         r_out_last, n_out_last;

    logic [EW-1:0] r_mem [WINDOW_MAX];
    logic [EW-1:0] r_rd_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;

    logic [CW-1:0] w_ext;
    logic [CW-1:0] eff_w;
    logic [PW-1:0] cand_pos;
    logic signed [swm_pkg::SAMPLE_W-1:0] cand_val;
    logic [PW-1:0] age;
    logic [SW-1:0] sum_head1;
    logic [SW-1:0] sum_tail;
    logic [SW-1:0] sum_push;
    logic [IW-1:0] head_inc;
    logic [IW-1:0] tail_idx;
    logic [IW-1:0] push_idx;
    logic [LW-1:0] seen_inc;
    logic [PW-1:0] pos_inc;
    logic          out_free;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == swm_pkg::S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tlast   = r_out_last;

    // window size clamped to 1..WINDOW_MAX
    always_comb begin
        w_ext = CW'(r_window_size);
        if (w_ext == '0) begin
            eff_w = CW'(1);
        end else if (w_ext > CW'(WINDOW_MAX)) begin
            eff_w = CW'(WINDOW_MAX);
        end else begin
            eff_w = w_ext;
        end
    end

    // candidate entry and its age
    always_comb begin
        cand_pos = r_rd_data[PW-1:0];
        cand_val = $signed(r_rd_data[EW-1:PW]);
        if (r_pos >= cand_pos) begin
            age = r_pos - cand_pos;
        end else begin
            age = PW'(POS_MOD) + r_pos - cand_pos;
        end
    end

    // circular indexes
    always_comb begin
        sum_head1 = SW'(r_head) + SW'(1);
        sum_tail  = SW'(r_head) + SW'(r_qlen) - SW'(1);
        sum_push  = SW'(r_head) + SW'(r_qlen);
        head_inc  = (sum_head1 >= SW'(WINDOW_MAX)) ? IW'(sum_head1 - SW'(WINDOW_MAX))
                                                   : IW'(sum_head1);
        tail_idx  = (sum_tail >= SW'(WINDOW_MAX)) ? IW'(sum_tail - SW'(WINDOW_MAX))
                                                  : IW'(sum_tail);
        push_idx  = (sum_push >= SW'(WINDOW_MAX)) ? IW'(sum_push - SW'(WINDOW_MAX))
                                                  : IW'(sum_push);
        seen_inc  = (r_seen < LW'(WINDOW_MAX)) ? r_seen + LW'(1) : r_seen;
        pos_inc   = (r_pos == PW'(POS_MOD - 1)) ? '0 : r_pos + PW'(1);
        out_free  = !r_out_valid || i_m_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= swm_pkg::S_IDLE;
            r_window_size <= swm_pkg::CFG_W'(1);
            r_qlen        <= '0;
            r_head        <= '0;
            r_pos         <= '0;
            r_seen        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_window_size <= n_window_size;
            r_qlen        <= n_qlen;
            r_head        <= n_head;
            r_pos         <= n_pos;
            r_seen        <= n_seen;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_last     <= n_last;
        r_head_val <= n_head_val;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    // candidate memory
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= {r_sample, r_pos};
        end
    end

    always_comb begin
        n_state       = r_state;
        n_window_size = r_window_size;
        n_sample      = r_sample;
        n_last        = r_last;
        n_qlen        = r_qlen;
        n_head        = r_head;
        n_pos         = r_pos;
        n_seen        = r_seen;
        n_head_val    = r_head_val;
        n_out_valid   = r_out_valid;
        n_out_data    = r_out_data;
        n_out_last    = r_out_last;
        rd_en         = 1'b0;
        rd_addr       = r_head;
        wr_en         = 1'b0;
        wr_addr       = push_idx;

        if (i_cfg_valid) begin
            n_window_size = i_cfg_data;
        end
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            swm_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_sample = $signed(i_s_tdata[swm_pkg::SAMPLE_W-1:0]);
                    n_last   = i_s_tlast;
                    if (i_s_tuser) begin
                        n_qlen = '0;
                        n_head = '0;
                        n_pos  = '0;
                        n_seen = '0;
                    end
                    n_state = swm_pkg::S_DROP_RD;
                end
            end
            swm_pkg::S_DROP_RD: begin
                if (r_qlen == '0) begin
                    n_state = swm_pkg::S_EVICT_RD;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_head;
                    n_state = swm_pkg::S_DROP_CMP;
                end
            end
            swm_pkg::S_DROP_CMP: begin
                if (AW'(age) >= AW'(eff_w)) begin
                    n_head  = head_inc;
                    n_qlen  = r_qlen - LW'(1);
                    n_state = swm_pkg::S_DROP_RD;
                end else begin
                    n_head_val = cand_val;
                    n_state    = swm_pkg::S_EVICT_RD;
                end
            end
            swm_pkg::S_EVICT_RD: begin
                if (r_qlen == '0) begin
                    n_state = swm_pkg::S_PUSH;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = tail_idx;
                    n_state = swm_pkg::S_EVICT_CMP;
                end
            end
            swm_pkg::S_EVICT_CMP: begin
                if (r_sample >= cand_val) begin
                    n_qlen  = r_qlen - LW'(1);
                    n_state = swm_pkg::S_EVICT_RD;
                end else begin
                    n_state = swm_pkg::S_PUSH;
                end
            end
            swm_pkg::S_PUSH: begin
                if (out_free) begin
                    wr_en  = 1'b1;
                    n_qlen = r_qlen + LW'(1);
                    n_seen = seen_inc;
                    n_pos  = pos_inc;
                    if (CW'(seen_inc) >= eff_w) begin
                        n_out_valid = 1'b1;
                        n_out_data  = (r_qlen == '0) ? r_sample : r_head_val;
                        n_out_last  = r_last;
                    end
                    if (r_last) begin
                        n_qlen = '0;
                        n_head = '0;
                        n_pos  = '0;
                        n_seen = '0;
                    end
                    n_state = swm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/swm_checker.sv
// swm_checker: port-level assertions for sliding_window_maximum_top
// depends on swm_pkg; attached to the top level by the bind below

module swm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_tvalid,
    input logic                        i_s_tready,
    input logic                        i_m_tvalid,
    input logic                        i_m_tready,
    input logic [swm_pkg::TDATA_W-1:0] i_m_tdata,
    input logic                        i_m_tlast
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast))
        else $error("result beat changed while stalled");

    // one item at a time: busy right after an input beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input accepted while previous item in work");

    // a new result appears only as an item finishes
    a_result_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_m_tvalid) |-> i_s_tready && !$past(i_s_tready))
        else $error("result appeared outside item completion");

    // reset leaves the block empty and ready
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid && i_s_tready)
        else $error("block not idle after reset");

endmodule

bind sliding_window_maximum_top swm_checker u_swm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tlast  (o_m_tlast)
);
